// ===== sv/sbct_pkg.sv =====
`timescale 1ns / 1ps
package sbct_pkg;

   // frame step format, unsigned q0.16
   localparam int STEP_FRAC = 16;
   localparam logic [STEP_FRAC-1:0] STEP_RESET = 16'd1092;

   // per-item flags that ride alongside the dividers
   typedef struct packed {
      logic boxes;      // both objects carry a box
      logic broad_miss; // swept box misses the target
      logic now;        // overlap at frame start
      logic x_zero;     // x displacement is zero
      logic y_zero;     // y displacement is zero
      logic dxe_neg;    // x entry distance negative
      logic dye_neg;    // y entry distance negative
      logic neg_xe;
      logic neg_xx;
      logic neg_ye;
      logic neg_yx;
      logic sat_xe;
      logic sat_xx;
      logic sat_ye;
      logic sat_yx;
   } sbct_sb_type;

endpackage

// ===== sv/swept_box_collision_time.sv =====
`timescale 1ns / 1ps
// swept box pair test: each item carries a moving box, a target box and their
// relative velocity; the block scales the velocity by frame_step, rejects pairs
// that lack boxes or whose swept box misses the target, reports overlap at frame
// start as time 0, and otherwise returns the entry time fraction and the contact
// normal. one item enters per cycle while the pipeline is not stalled; the four
// restoring dividers, one quotient bit per stage, make up most of its depth.
// the pipeline stalls as a whole only while a result waits on rsp_tready.
module swept_box_collision_time #(
   parameter int COORD_BITS     = 24,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [sbct_pkg::STEP_FRAC-1:0] csr_wr_data,  // frame_step
   input  logic req_tvalid,
   output logic req_tready,
   // mover_left, mover_right, mover_top, mover_bottom, target_left,
   // target_right, target_top, target_bottom, rel_vel_x, rel_vel_y
   input  logic [((10*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tuser,                               // both_have_boxes
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit_time, normal_x, normal_y
   output logic [((TIME_FRAC_BITS+5+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tuser                                // overlapping_now
);
   import sbct_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int NW  = CB + 1;              // magnitude width
   localparam int QB  = TIME_FRAC_BITS + 2;  // quotient bits
   localparam int TW  = QB + 2;              // signed time width
   localparam int NST = QB + 6;              // pipeline stages
   localparam int OW  = ((TIME_FRAC_BITS+5+7)/8)*8;
   localparam int PW  = CB + STEP_FRAC + 1;  // product width

   localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< TIME_FRAC_BITS;
   localparam logic signed [TW-1:0] T_UNB = TW'(1) <<< QB;

   // frame step register
   logic [STEP_FRAC-1:0] fs_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         fs_ff <= csr_wr_data;
      end
   end

   // global advance: only a waiting result holds the pipe
   logic en;
   logic vld_ff [NST];
   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < NST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // unpack input fields
   logic signed [CB-1:0] in_f [10];
   for (genvar k = 0; k < 10; k++) begin : g_unpack
      assign in_f[k] = req_tdata[k*CB +: CB];
   end

   // stage a: velocity times frame step
   logic signed [CB-1:0] ml_a_ff, mr_a_ff, mt_a_ff, mb_a_ff;
   logic signed [CB-1:0] tl_a_ff, tr_a_ff, tt_a_ff, tb_a_ff;
   logic signed [PW-1:0] px_a_ff, py_a_ff;
   logic                 boxes_a_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ml_a_ff <= in_f[0]; mr_a_ff <= in_f[1];
         mt_a_ff <= in_f[2]; mb_a_ff <= in_f[3];
         tl_a_ff <= in_f[4]; tr_a_ff <= in_f[5];
         tt_a_ff <= in_f[6]; tb_a_ff <= in_f[7];
         px_a_ff <= PW'(in_f[8] * $signed({1'b0, fs_ff}));
         py_a_ff <= PW'(in_f[9] * $signed({1'b0, fs_ff}));
         boxes_a_ff <= req_tuser;
      end
   end

   // stage b: round to nearest, ties upward
   logic signed [PW-1:0] rx_in, ry_in;
   assign rx_in = px_a_ff + (PW'(1) <<< (STEP_FRAC-1));
   assign ry_in = py_a_ff + (PW'(1) <<< (STEP_FRAC-1));

   logic signed [CB-1:0] ml_b_ff, mr_b_ff, mt_b_ff, mb_b_ff;
   logic signed [CB-1:0] tl_b_ff, tr_b_ff, tt_b_ff, tb_b_ff;
   logic signed [CB:0]   dx_b_ff, dy_b_ff;
   logic                 boxes_b_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ml_b_ff <= ml_a_ff; mr_b_ff <= mr_a_ff;
         mt_b_ff <= mt_a_ff; mb_b_ff <= mb_a_ff;
         tl_b_ff <= tl_a_ff; tr_b_ff <= tr_a_ff;
         tt_b_ff <= tt_a_ff; tb_b_ff <= tb_a_ff;
         dx_b_ff <= rx_in[PW-1:STEP_FRAC];
         dy_b_ff <= ry_in[PW-1:STEP_FRAC];
         boxes_b_ff <= boxes_a_ff;
      end
   end

   // stage c: broad phase, start overlap, distances and magnitudes
   logic signed [CB+1:0] ml_w, mr_w, mt_w, mb_w, tl_w, tr_w, tt_w, tb_w, dx_w, dy_w;
   logic signed [CB+1:0] bl, br, bt, bb;
   logic signed [CB:0]   dxe, dxx, dye, dyx;
   logic                 dx_pos, dy_pos, broad_in, now_in;

   always_comb begin
      ml_w = {{2{ml_b_ff[CB-1]}}, ml_b_ff};
      mr_w = {{2{mr_b_ff[CB-1]}}, mr_b_ff};
      mt_w = {{2{mt_b_ff[CB-1]}}, mt_b_ff};
      mb_w = {{2{mb_b_ff[CB-1]}}, mb_b_ff};
      tl_w = {{2{tl_b_ff[CB-1]}}, tl_b_ff};
      tr_w = {{2{tr_b_ff[CB-1]}}, tr_b_ff};
      tt_w = {{2{tt_b_ff[CB-1]}}, tt_b_ff};
      tb_w = {{2{tb_b_ff[CB-1]}}, tb_b_ff};
      dx_w = {dx_b_ff[CB], dx_b_ff};
      dy_w = {dy_b_ff[CB], dy_b_ff};
      dx_pos = !dx_b_ff[CB] && (dx_b_ff != '0);
      dy_pos = !dy_b_ff[CB] && (dy_b_ff != '0);
      bl = dx_pos ? ml_w : ml_w + dx_w;
      br = dx_pos ? mr_w + dx_w : mr_w;
      bt = dy_pos ? mt_w + dy_w : mt_w;
      bb = dy_pos ? mb_w : mb_w + dy_w;
      broad_in = (bl > tr_w) || (br < tl_w) || (bt < tb_w) || (bb > tt_w);
      now_in = !((ml_w > tr_w) || (mr_w < tl_w) || (mt_w < tb_w) || (mb_w > tt_w));
      // entry and exit distances per axis, each fits in NW bits
      if (dx_pos) begin
         dxe = NW'(tl_w - mr_w) ; dxx = NW'(tr_w - ml_w);
      end else begin
         dxe = NW'(tr_w - ml_w) ; dxx = NW'(tl_w - mr_w);
      end
      if (dy_pos) begin
         dye = NW'(tb_w - mt_w) ; dyx = NW'(tt_w - mb_w);
      end else begin
         dye = NW'(tt_w - mb_w) ; dyx = NW'(tb_w - mt_w);
      end
   end

   function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
      mag = v[NW-1] ? NW'(-v) : v;
   endfunction

   logic [NW-1:0] uxe_c_ff, uxx_c_ff, uye_c_ff, uyx_c_ff, udx_c_ff, udy_c_ff;
   logic          sxe_c_ff, sxx_c_ff, sye_c_ff, syx_c_ff, sdx_c_ff, sdy_c_ff;
   logic          xz_c_ff, yz_c_ff, broad_c_ff, now_c_ff, boxes_c_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         uxe_c_ff <= mag(dxe); uxx_c_ff <= mag(dxx);
         uye_c_ff <= mag(dye); uyx_c_ff <= mag(dyx);
         udx_c_ff <= mag(dx_b_ff); udy_c_ff <= mag(dy_b_ff);
         sxe_c_ff <= dxe[CB]; sxx_c_ff <= dxx[CB];
         sye_c_ff <= dye[CB]; syx_c_ff <= dyx[CB];
         sdx_c_ff <= dx_b_ff[CB]; sdy_c_ff <= dy_b_ff[CB];
         xz_c_ff <= (dx_b_ff == '0); yz_c_ff <= (dy_b_ff == '0);
         broad_c_ff <= broad_in; now_c_ff <= now_in; boxes_c_ff <= boxes_b_ff;
      end
   end

   // stage d: quotient overflow check and sign of each quotient
   sbct_sb_type  sb_in;
   always_comb begin
      sb_in.boxes      = boxes_c_ff;
      sb_in.broad_miss = broad_c_ff;
      sb_in.now        = now_c_ff;
      sb_in.x_zero     = xz_c_ff;
      sb_in.y_zero     = yz_c_ff;
      sb_in.dxe_neg    = sxe_c_ff;
      sb_in.dye_neg    = sye_c_ff;
      sb_in.neg_xe     = sxe_c_ff ^ sdx_c_ff;
      sb_in.neg_xx     = sxx_c_ff ^ sdx_c_ff;
      sb_in.neg_ye     = sye_c_ff ^ sdy_c_ff;
      sb_in.neg_yx     = syx_c_ff ^ sdy_c_ff;
      sb_in.sat_xe     = {2'b00, uxe_c_ff} >= {udx_c_ff, 2'b00};
      sb_in.sat_xx     = {2'b00, uxx_c_ff} >= {udx_c_ff, 2'b00};
      sb_in.sat_ye     = {2'b00, uye_c_ff} >= {udy_c_ff, 2'b00};
      sb_in.sat_yx     = {2'b00, uyx_c_ff} >= {udy_c_ff, 2'b00};
   end

   sbct_sb_type   sb_d_ff;
   logic [NW-1:0] uxe_d_ff, uxx_d_ff, uye_d_ff, uyx_d_ff, udx_d_ff, udy_d_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sb_d_ff  <= sb_in;
         uxe_d_ff <= uxe_c_ff; uxx_d_ff <= uxx_c_ff;
         uye_d_ff <= uye_c_ff; uyx_d_ff <= uyx_c_ff;
         udx_d_ff <= udx_c_ff; udy_d_ff <= udy_c_ff;
      end
   end

   // four dividers in lockstep, flags delayed alongside
   logic [QB-1:0] qxe, qxx, qye, qyx;
   sbct_div #(.NW(NW), .QB(QB)) u_div_xe (.clock(clock), .en(en),
      .num_mag(uxe_d_ff), .den_mag(udx_d_ff), .quo(qxe));
   sbct_div #(.NW(NW), .QB(QB)) u_div_xx (.clock(clock), .en(en),
      .num_mag(uxx_d_ff), .den_mag(udx_d_ff), .quo(qxx));
   sbct_div #(.NW(NW), .QB(QB)) u_div_ye (.clock(clock), .en(en),
      .num_mag(uye_d_ff), .den_mag(udy_d_ff), .quo(qye));
   sbct_div #(.NW(NW), .QB(QB)) u_div_yx (.clock(clock), .en(en),
      .num_mag(uyx_d_ff), .den_mag(udy_d_ff), .quo(qyx));

   sbct_sb_type sb_dl_ff [QB];
   always_ff @(posedge clock) begin
      if (en) begin
         sb_dl_ff[0] <= sb_d_ff;
         for (int i = 1; i < QB; i++) sb_dl_ff[i] <= sb_dl_ff[i-1];
      end
   end

   // stage e: signed times; overflowed quotients clamp above one,
   // a zero displacement makes the axis unbounded
   function automatic logic signed [TW-1:0] stime(input logic [QB-1:0] q,
                                                 input logic sat, input logic neg);
      logic [QB-1:0] m;
      m = sat ? {QB{1'b1}} : q;
      stime = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
   endfunction

   sbct_sb_type sb_q;
   logic signed [TW-1:0] txe_e_ff, txx_e_ff, tye_e_ff, tyx_e_ff;
   sbct_sb_type          sb_e_ff;
   assign sb_q = sb_dl_ff[QB-1];
   always_ff @(posedge clock) begin
      if (en) begin
         sb_e_ff  <= sb_q;
         txe_e_ff <= sb_q.x_zero ? -T_UNB : stime(qxe, sb_q.sat_xe, sb_q.neg_xe);
         txx_e_ff <= sb_q.x_zero ?  T_UNB : stime(qxx, sb_q.sat_xx, sb_q.neg_xx);
         tye_e_ff <= sb_q.y_zero ? -T_UNB : stime(qye, sb_q.sat_ye, sb_q.neg_ye);
         tyx_e_ff <= sb_q.y_zero ?  T_UNB : stime(qyx, sb_q.sat_yx, sb_q.neg_yx);
      end
   end

   // stage f: pick the later entry, decide hit and normal, output register
   logic signed [TW-1:0]     entry, exit_t;
   logic                     x_later, hit_ok;
   logic [TIME_FRAC_BITS:0]  hit_in;
   logic [1:0]               nx_in, ny_in;
   logic                     ovl_in;
   always_comb begin
      x_later = txe_e_ff > tye_e_ff;
      entry   = x_later ? txe_e_ff : tye_e_ff;
      exit_t  = (txx_e_ff < tyx_e_ff) ? txx_e_ff : tyx_e_ff;
      hit_ok  = !((entry > exit_t) || (txe_e_ff[TW-1] && tye_e_ff[TW-1]) ||
                  (txe_e_ff > T_ONE) || (tye_e_ff > T_ONE));
      hit_in  = T_ONE[TIME_FRAC_BITS:0];
      nx_in   = 2'b00;
      ny_in   = 2'b00;
      ovl_in  = 1'b0;
      if (sb_e_ff.boxes && !sb_e_ff.broad_miss) begin
         if (sb_e_ff.now) begin
            hit_in = '0;
            ovl_in = 1'b1;
         end else if (hit_ok) begin
            hit_in = entry[TIME_FRAC_BITS:0];
            if (x_later) begin
               nx_in = sb_e_ff.dxe_neg ? 2'b01 : 2'b11;
            end else begin
               ny_in = sb_e_ff.dye_neg ? 2'b01 : 2'b11;
            end
         end
      end
   end

   logic [TIME_FRAC_BITS:0] hit_ff;
   logic [1:0]              nx_ff, ny_ff;
   logic                    ovl_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         ovl_ff <= ovl_in;
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = OW'({ny_ff, nx_ff, hit_ff});
   assign rsp_tuser  = ovl_ff;

endmodule

// ===== sv/sbct_div.sv =====
`timescale 1ns / 1ps
module sbct_div #(
   parameter int NW = 25,
   parameter int QB = 18
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_mag,
   input  logic [NW-1:0] den_mag,
   output logic [QB-1:0] quo
);
   // restoring division, one quotient bit per stage; caller keeps num < 4*den
   logic [NW-1:0] r_ff [QB];
   logic [NW-1:0] d_ff [QB];
   logic [QB-1:0] n_ff [QB];
   logic [QB-1:0] q_ff [QB];

   for (genvar i = 0; i < QB; i++) begin : g_stage
      logic [NW-1:0] r_src, d_src;
      logic [QB-1:0] n_src, q_src;
      logic [NW:0]   t;
      logic [NW:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign r_src = {2'b00, num_mag[NW-1:2]};
         assign d_src = den_mag;
         assign n_src = {num_mag[1:0], {(QB-2){1'b0}}};
         assign q_src = '0;
      end else begin : g_next
         assign r_src = r_ff[i-1];
         assign d_src = d_ff[i-1];
         assign n_src = n_ff[i-1];
         assign q_src = q_ff[i-1];
      end

      assign t    = {r_src, n_src[QB-1]};
      assign diff = t - {1'b0, d_src};
      assign ge   = (t >= {1'b0, d_src});

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i] <= ge ? diff[NW-1:0] : t[NW-1:0];
            d_ff[i] <= d_src;
            n_ff[i] <= {n_src[QB-2:0], 1'b0};
            q_ff[i] <= {q_src[QB-2:0], ge};
         end
      end
   end

   assign quo = q_ff[QB-1];

endmodule
